>>> rtl/lc2k_pkg.sv
// Shared types and constants of the LC-2K instruction executor.
// Holds request and opcode codes, field widths and the control/status structs.
// No dependencies.
package lc2k_pkg;

  localparam int unsigned DATA_W            = 32;
  localparam int unsigned ADDR_W            = 16;
  localparam int unsigned PC_W              = 16;
  localparam int unsigned CNT_W             = 32;
  localparam int unsigned REQ_W             = 2;
  localparam int unsigned OPC_W             = 3;
  localparam int unsigned OFF_W             = 16;
  localparam int unsigned REG_COUNT         = 8;
  localparam int unsigned RF_IDX_W          = $clog2(REG_COUNT);
  localparam int unsigned MEM_WORDS_DEFAULT = 65536;

  localparam int unsigned OPC_LSB = 22;
  localparam int unsigned RA_LSB  = 19;
  localparam int unsigned RB_LSB  = 16;
  localparam int unsigned RD_LSB  = 0;

  localparam int unsigned S_TDATA_W = ADDR_W + DATA_W;
  localparam int unsigned S_TUSER_W = REQ_W;
  localparam int unsigned RES_W     = DATA_W + PC_W + 1 + CNT_W;
  localparam int unsigned M_TDATA_W = ((RES_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_EXEC  = 2'd1,
    REQ_RDMEM = 2'd2,
    REQ_RDREG = 2'd3
  } req_type_e;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } opcode_e;

  typedef struct packed {
    logic capture;
    logic mem_wr;
    logic mem_rd;
    logic reg_rd;
    logic fetch;
    logic decode;
    logic exec;
    logic load_wb;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    req_type_e req_type;
    logic      halted;
    opcode_e   opcode;
  } status_t;

endpackage

>>> rtl/lc2k_ctrl.sv
// Request sequencer of the LC-2K instruction executor. Each request passes
// dispatch and response, an execute adds decode and execute, lw writeback.
// Depends on lc2k_pkg.
module lc2k_ctrl import lc2k_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DECODE,
    ST_EXECUTE,
    ST_WRITEBACK,
    ST_RESP
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_RESP;
        unique case (status_i.req_type)
          REQ_LOAD:  cmd_o.mem_wr = !status_i.halted;
          REQ_EXEC: begin
            if (!status_i.halted) begin
              cmd_o.fetch = 1'b1;
              state_d     = ST_DECODE;
            end
          end
          REQ_RDMEM: cmd_o.mem_rd = 1'b1;
          REQ_RDREG: cmd_o.reg_rd = 1'b1;
          default:   state_d = ST_RESP;
        endcase
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = ST_EXECUTE;
      end
      ST_EXECUTE: begin
        cmd_o.exec = 1'b1;
        state_d    = (status_i.opcode == OP_LW) ? ST_WRITEBACK : ST_RESP;
      end
      ST_WRITEBACK: begin
        cmd_o.load_wb = 1'b1;
        state_d       = ST_RESP;
      end
      ST_RESP: begin
        if (slot_free) begin
          cmd_o.result_load = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_no_exec_when_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> !status_i.halted)
    else $error("execute issued while halted");

  a_accept_dispatches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DISPATCH))
    else $error("accepted request not dispatched");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result raised outside response state");

endmodule

>>> rtl/lc2k_dpath.sv
// Datapath of the LC-2K instruction executor.
// Holds word memory, register file, program counter, halt flag, counter and result.
// Depends on lc2k_pkg; driven by lc2k_ctrl commands.
module lc2k_dpath import lc2k_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [S_TDATA_W-1:0] req_data_i,
  input  logic [S_TUSER_W-1:0] req_user_i,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  output logic [M_TDATA_W-1:0] res_data_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  req_type_e           req_type_q;
  logic [ADDR_W-1:0]   req_addr_q;
  logic [DATA_W-1:0]   req_wdata_q;

  logic [DATA_W-1:0]   mem_q [MEM_WORDS];
  logic [DATA_W-1:0]   mem_rdata_q;
  logic                mem_re;
  logic                mem_we;
  logic [AW-1:0]       mem_raddr;
  logic [AW-1:0]       mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;

  logic [DATA_W-1:0]   rf_q [REG_COUNT];
  logic [DATA_W-1:0]   rfa_q;
  logic [DATA_W-1:0]   rfb_q;
  logic [RF_IDX_W-1:0] rfa_idx;
  logic                rf_we;
  logic [RF_IDX_W-1:0] rf_widx;
  logic [DATA_W-1:0]   rf_wdata;

  logic [DATA_W-1:0]   ir_q;
  opcode_e             op;
  logic [RF_IDX_W-1:0] ra;
  logic [RF_IDX_W-1:0] rb;
  logic [RF_IDX_W-1:0] rd;
  logic [DATA_W-1:0]   off;
  logic [DATA_W-1:0]   ea_sum;
  logic [AW-1:0]       ea;

  logic [AW-1:0]       pc_q;
  logic [AW-1:0]       pc_d;
  logic [AW-1:0]       pc_inc;
  logic                halt_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [DATA_W-1:0]   rd_val;
  logic [M_TDATA_W-1:0] res_q;

  assign op     = opcode_e'(ir_q[OPC_LSB +: OPC_W]);
  assign ra     = ir_q[RA_LSB +: RF_IDX_W];
  assign rb     = ir_q[RB_LSB +: RF_IDX_W];
  assign rd     = ir_q[RD_LSB +: RF_IDX_W];
  assign off    = {{(DATA_W-OFF_W){ir_q[OFF_W-1]}}, ir_q[OFF_W-1:0]};
  assign ea_sum = rfa_q + off;
  assign ea     = ea_sum[AW-1:0];
  assign pc_inc = pc_q + AW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q  <= req_type_e'(req_user_i);
      req_addr_q  <= req_data_i[ADDR_W-1:0];
      req_wdata_q <= req_data_i[ADDR_W +: DATA_W];
    end
  end

  // word memory: one write and one registered read port
  assign mem_re    = cmd_i.fetch || cmd_i.mem_rd || (cmd_i.exec && op == OP_LW);
  assign mem_we    = cmd_i.mem_wr || (cmd_i.exec && op == OP_SW);
  assign mem_raddr = cmd_i.fetch ? pc_q : (cmd_i.exec ? ea : req_addr_q[AW-1:0]);
  assign mem_waddr = cmd_i.exec ? ea : req_addr_q[AW-1:0];
  assign mem_wdata = cmd_i.exec ? rfb_q : req_wdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  // latch instruction and operands from the fetched word, rfa_q also on a reg read
  assign rfa_idx = cmd_i.decode ? mem_rdata_q[RA_LSB +: RF_IDX_W]
                                : req_addr_q[RF_IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      ir_q  <= mem_rdata_q;
      rfb_q <= rf_q[mem_rdata_q[RB_LSB +: RF_IDX_W]];
    end
    if (cmd_i.decode || cmd_i.reg_rd) begin
      rfa_q <= rf_q[rfa_idx];
    end
  end

  always_comb begin
    rf_we    = 1'b0;
    rf_widx  = rd;
    rf_wdata = '0;
    pc_d     = pc_q;
    if (cmd_i.exec) begin
      pc_d = pc_inc;
      unique case (op)
        OP_ADD: begin
          rf_we    = 1'b1;
          rf_wdata = rfa_q + rfb_q;
        end
        OP_NOR: begin
          rf_we    = 1'b1;
          rf_wdata = ~(rfa_q | rfb_q);
        end
        OP_BEQ: begin
          if (rfa_q == rfb_q) begin
            pc_d = pc_inc + off[AW-1:0];
          end
        end
        OP_JALR: begin
          rf_we    = 1'b1;
          rf_widx  = rb;
          rf_wdata = DATA_W'(pc_inc);
          pc_d     = (ra == rb) ? pc_inc : rfa_q[AW-1:0];
        end
        default: pc_d = pc_inc;
      endcase
    end else if (cmd_i.load_wb) begin
      rf_we    = 1'b1;
      rf_widx  = rb;
      rf_wdata = mem_rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_q[i] <= '0;
      end
      pc_q   <= '0;
      halt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (rf_we) begin
        rf_q[rf_widx] <= rf_wdata;
      end
      pc_q <= pc_d;
      if (cmd_i.exec) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (op == OP_HALT) begin
          halt_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (req_type_q)
      REQ_RDMEM: rd_val = mem_rdata_q;
      REQ_RDREG: rd_val = rfa_q;
      default:   rd_val = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      res_q <= M_TDATA_W'({cnt_q, halt_q, PC_W'(pc_q), rd_val});
    end
  end

  assign res_data_o        = res_q;
  assign status_o.req_type = req_type_q;
  assign status_o.halted   = halt_q;
  assign status_o.opcode   = op;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared");

  a_no_write_when_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !halt_q)
    else $error("memory written after halt");

  a_count_tracks_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(cnt_q))
    else $error("instruction count moved without execute");

endmodule

>>> rtl/lc2k_instruction_executor.sv
// Top level of the LC-2K instruction executor.
// Joins the request sequencer (lc2k_ctrl) and the datapath (lc2k_dpath).
// Depends on lc2k_pkg.
//
// Each request gives one result. Every request passes through dispatch and
// response; an execute before halt also through decode and execute, and an lw
// also through writeback: the instruction fetch and the data access each go
// through the registered read port of the word memory, and operands come from
// a registered register-file read. A finished result waits in an output
// register while the next request is accepted; the block stalls only when a
// second result is ready before the first was taken.
// MEM_WORDS must be a power of two; addresses and the program counter wrap at
// it. Memory words are undefined until loaded and need no clearing after reset.
module lc2k_instruction_executor import lc2k_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // address [15:0], write_data [47:16]
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // req_type [1:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // read_data [31:0], program_counter [47:32], halted [48],
  // executed_count [80:49], zero [87:81]
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  cmd_t    cmd;
  status_t status;

  lc2k_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lc2k_dpath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_data_i (s_axis_tdata_i),
    .req_user_i (s_axis_tuser_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .res_data_o (m_axis_tdata_o)
  );

endmodule

>>> test/tb_top.sv
// Self-checking testbench for lc2k_instruction_executor: loads programs, steps the core and
// reads memory and registers, checking every result against a cycle-free shadow of the core.
// Depends on lc2k_pkg and the executor RTL.
module tb_top;
  import lc2k_pkg::*;

  typedef struct packed {
    logic [M_TDATA_W-RES_W-1:0] pad;
    logic [CNT_W-1:0]           icount;
    logic                       halted;
    logic [PC_W-1:0]            pc;
    logic [DATA_W-1:0]          rdata;
  } result_t;

  class lc2k_shadow;
    logic [PC_W-1:0]   pc = '0;
    logic [DATA_W-1:0] regs [REG_COUNT];
    logic [DATA_W-1:0] words [bit [ADDR_W-1:0]];
    logic [ADDR_W-1:0] written [$];
    logic              halted = 1'b0;
    logic [CNT_W-1:0]  icount = '0;
    result_t           results_due [$];
    int                errors = 0;

    function new();
      foreach (regs[i]) regs[i] = '0;
    endfunction

    function void store_word(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      if (!words.exists(addr)) written.push_back(addr);
      words[addr] = data;
    endfunction

    function void execute_word();
      logic [DATA_W-1:0] w;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [PC_W-1:0]   nxt;
      logic [ADDR_W-1:0] ea;
      opcode_e           op;
      w   = words[pc];
      op  = opcode_e'(w[OPC_LSB +: OPC_W]);
      a   = regs[w[RA_LSB +: RF_IDX_W]];
      b   = regs[w[RB_LSB +: RF_IDX_W]];
      nxt = pc + 16'd1;
      ea  = a[ADDR_W-1:0] + w[OFF_W-1:0];
      icount++;
      case (op)
        OP_ADD:  regs[w[RD_LSB +: RF_IDX_W]] = a + b;
        OP_NOR:  regs[w[RD_LSB +: RF_IDX_W]] = ~(a | b);
        OP_LW:   regs[w[RB_LSB +: RF_IDX_W]] = words[ea];
        OP_SW:   store_word(ea, b);
        OP_BEQ:  if (a == b) nxt = pc + 16'd1 + w[OFF_W-1:0];
        OP_JALR: begin
          regs[w[RB_LSB +: RF_IDX_W]] = {16'd0, nxt};
          nxt = regs[w[RA_LSB +: RF_IDX_W]][PC_W-1:0];
        end
        OP_HALT: halted = 1'b1;
        default: ;
      endcase
      pc = nxt;
    endfunction

    function void take_request(req_type_e kind, logic [ADDR_W-1:0] addr,
                               logic [DATA_W-1:0] data);
      result_t r;
      r = '0;
      case (kind)
        REQ_LOAD:  if (!halted) store_word(addr, data);
        REQ_EXEC:  if (!halted) execute_word();
        REQ_RDMEM: r.rdata = words[addr];
        default:   r.rdata = regs[addr[RF_IDX_W-1:0]];
      endcase
      r.pc     = pc;
      r.halted = halted;
      r.icount = icount;
      results_due.push_back(r);
    endfunction

    function void match_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 100)
          $display("%0t: %s expected %h got %h", $time, field, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing due: expected none got %h", $time, got);
        return;
      end
      want = results_due.pop_front();
      match_field("read_data", want.rdata, got.rdata);
      match_field("program_counter", 32'(want.pc), 32'(got.pc));
      match_field("halted", 32'(want.halted), 32'(got.halted));
      match_field("executed_count", want.icount, got.icount);
      match_field("padding", 32'(want.pad), 32'(got.pad));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  lc2k_shadow shadow;
  int         sent = 0;
  bit         calm = 1'b0;
  bit         choke_req = 1'b0;

  lc2k_instruction_executor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
      end else if (choke_req) begin
        choke_req = 1'b0;
        hold_left = 60;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 5);
      end
      m_ready <= rst_ni && (hold_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) shadow.check_result(m_tdata);
  end

  function automatic logic [DATA_W-1:0] encode(opcode_e op, logic [2:0] ra, logic [2:0] rb,
                                               logic [15:0] low);
    encode = {7'($urandom), op, ra, rb, low};
  endfunction

  function automatic logic [DATA_W-1:0] random_data();
    random_data = ($urandom_range(0, 1) == 1) ? $urandom : 32'($urandom_range(0, 15));
  endfunction

  function automatic logic [DATA_W-1:0] random_instruction();
    opcode_e     op;
    logic [15:0] low;
    op  = opcode_e'($urandom_range(0, 7));
    low = ($urandom_range(0, 2) != 0) ? 16'($urandom_range(0, 16)) - 16'd8 : 16'($urandom);
    if (op == OP_HALT) op = OP_NOOP;
    random_instruction = encode(op, 3'($urandom), 3'($urandom), low);
  endfunction

  task automatic issue(req_type_e kind, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {data, addr};
    s_tuser <= kind;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    shadow.take_request(kind, addr, data);
    sent++;
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (shadow.results_due.size() != 0);
  endtask

  // Load the fetch word, and the data word of an lw, before stepping the core.
  // Replace a halt that data words left in the program path.
  task automatic step_core();
    logic [DATA_W-1:0] w;
    logic [ADDR_W-1:0] ea;
    forever begin
      if (!shadow.words.exists(shadow.pc)) begin
        issue(REQ_LOAD, shadow.pc, random_instruction());
        continue;
      end
      w  = shadow.words[shadow.pc];
      if (opcode_e'(w[OPC_LSB +: OPC_W]) == OP_HALT) begin
        issue(REQ_LOAD, shadow.pc, random_instruction());
        continue;
      end
      ea = shadow.regs[w[RA_LSB +: RF_IDX_W]][ADDR_W-1:0] + w[OFF_W-1:0];
      if (opcode_e'(w[OPC_LSB +: OPC_W]) == OP_LW && !shadow.words.exists(ea)) begin
        issue(REQ_LOAD, ea, random_data());
        continue;
      end
      break;
    end
    issue(REQ_EXEC, 16'($urandom), $urandom);
  endtask

  initial begin
    logic [DATA_W-1:0] jump_word;
    logic [ADDR_W-1:0] base;
    int                r;
    int                n;
    int                next_switch;
    bit                choked;
    bit                paused;
    shadow = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue(REQ_RDREG, 16'hFFFF, 32'hFFFF_FFFF);
    issue(REQ_RDREG, 16'h0000, 32'h0000_0000);
    jump_word = encode(OP_JALR, 3'd4, 3'd6, 16'($urandom));
    jump_word[31] = 1'b1;
    issue(REQ_LOAD, 16'hFFFF, jump_word);
    issue(REQ_LOAD, 16'hFFFE, 32'h7FFF_FFFF);
    issue(REQ_LOAD, 16'd0, encode(OP_LW, 3'd0, 3'd1, 16'hFFFF));
    issue(REQ_LOAD, 16'd1, encode(OP_LW, 3'd0, 3'd2, 16'hFFFE));
    issue(REQ_LOAD, 16'd2, encode(OP_ADD, 3'd2, 3'd2, 16'hFFFB));
    issue(REQ_LOAD, 16'd3, encode(OP_NOR, 3'd1, 3'd2, 16'h0004));
    issue(REQ_LOAD, 16'd4, encode(OP_SW, 3'd4, 3'd3, 16'h7FFF));
    issue(REQ_LOAD, 16'd5, encode(OP_BEQ, 3'd4, 3'd0, 16'hFFF9));
    repeat (7) issue(REQ_EXEC, 16'($urandom), $urandom);
    issue(REQ_RDMEM, 16'h7FFF, 32'd0);
    issue(REQ_RDMEM, 16'hFFFF, $urandom);
    issue(REQ_RDREG, 16'hFFFE, $urandom);
    drain();

    next_switch = 0;
    choked = 1'b0;
    paused = 1'b0;
    while (sent < 1650) begin
      if (sent >= 1500) begin
        calm = 1'b1;
      end else if (sent >= next_switch) begin
        calm = ($urandom_range(0, 3) == 0);
        next_switch += 100;
      end
      if (!choked && sent >= 600) begin
        choked = 1'b1;
        choke_req = 1'b1;
      end
      if (!paused && sent >= 1000) begin
        paused = 1'b1;
        drain();
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        step_core();
      end else if (r < 60) begin
        n = $urandom_range(2, 6);
        for (int i = 0; i < n; i++) issue(REQ_LOAD, shadow.pc + 16'(i), random_instruction());
      end else if (r < 72) begin
        issue(REQ_RDMEM, shadow.written[$urandom_range(0, shadow.written.size() - 1)],
              $urandom);
      end else if (r < 82) begin
        issue(REQ_RDREG, 16'($urandom), $urandom);
      end else if (r < 90) begin
        issue(REQ_LOAD, 16'($urandom), random_data());
      end else begin
        issue(REQ_LOAD, 16'($urandom_range(0, 31)), random_data());
      end
    end

    // Finish with register zero, jalr onto itself, halt and requests after halt.
    base = shadow.pc;
    issue(REQ_LOAD, base, encode(OP_ADD, 3'd1, 3'd2, 16'h0000));
    issue(REQ_LOAD, base + 16'd1, encode(OP_JALR, 3'd5, 3'd5, 16'($urandom)));
    issue(REQ_LOAD, base + 16'd2, encode(OP_HALT, 3'($urandom), 3'($urandom), 16'($urandom)));
    issue(REQ_LOAD, base + 16'd3, encode(OP_NOOP, 3'($urandom), 3'($urandom), 16'($urandom)));
    repeat (3) issue(REQ_EXEC, 16'($urandom), $urandom);
    issue(REQ_RDREG, 16'd5, $urandom);
    issue(REQ_RDREG, 16'd0, $urandom);
    issue(REQ_EXEC, 16'($urandom), $urandom);
    issue(REQ_LOAD, base + 16'd3, $urandom);
    issue(REQ_RDMEM, base + 16'd3, $urandom);
    issue(REQ_EXEC, 16'($urandom), $urandom);
    issue(REQ_RDMEM, base, $urandom);

    drain();
    repeat (20) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.results_due.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> lc2k_instruction_executor.f
rtl/lc2k_pkg.sv
rtl/lc2k_ctrl.sv
rtl/lc2k_dpath.sv
rtl/lc2k_instruction_executor.sv
test/tb_top.sv
